FILE: rtl/core/mmix_pkg.sv
// Package for the median-filtered quad-X motor mixer core.
// Holds widths, register reset values, register indexes and the limit struct.
// No dependencies; used by the top level and by mmix_mixer.
`timescale 1ns / 1ps
`default_nettype none

package mmix_pkg;

  // Default sizes of the term windows.
  localparam int unsigned WINDOW_DEPTH_DEF = 16;
  localparam int unsigned TERM_WIDTH_DEF   = 12;

  // Fixed field widths.
  localparam int unsigned PWM_W  = 12;
  localparam int unsigned WARM_W = 5;
  localparam int unsigned CADR_W = 3;

  // Warm-up counter saturates here.
  localparam logic [WARM_W-1:0] WARMUP_SAT = 5'd31;

  // Register reset values.
  localparam logic [PWM_W-1:0]  LIFT_MIN_RST  = 12'd1000;
  localparam logic [PWM_W-1:0]  LIFT_MAX_RST  = 12'd1800;
  localparam logic [PWM_W-1:0]  MOTOR_MIN_RST = 12'd1000;
  localparam logic [PWM_W-1:0]  MOTOR_MAX_RST = 12'd1999;
  localparam logic [PWM_W-1:0]  IDLE_PWM_RST  = 12'd1000;
  localparam logic [PWM_W-1:0]  KILL_THR_RST  = 12'd1500;
  localparam logic [WARM_W-1:0] WARMUP_RST    = 5'd16;

  // Configuration register indexes.
  typedef enum logic [CADR_W-1:0] {
    CFG_LIFT_MIN  = 3'd0,
    CFG_LIFT_MAX  = 3'd1,
    CFG_MOTOR_MIN = 3'd2,
    CFG_MOTOR_MAX = 3'd3,
    CFG_IDLE_PWM  = 3'd4,
    CFG_KILL_THR  = 3'd5,
    CFG_WARMUP    = 3'd6
  } cfg_idx_e;

  // Motor clamp limits handed to the mixer.
  typedef struct packed {
    logic [PWM_W-1:0] lo;
    logic [PWM_W-1:0] hi;
  } motor_lim_t;

endpackage : mmix_pkg

`default_nettype wire

FILE: rtl/core/median_filtered_quad_motor_mixer_core.sv
// Median-filtered quad-X motor mixer, top level.
// A result passes through three register stages (input/window stage, median stage,
// mix and output register). Throughput: one item per cycle when m_axis_tready allows;
// the rank compare over each window is done in parallel.
// Reset clears windows, warm-up counter and valid flags, and loads register defaults.
// Depends on mmix_pkg, mmix_window and mmix_mixer.
`timescale 1ns / 1ps
`default_nettype none

module median_filtered_quad_motor_mixer_core #(
  parameter int unsigned WINDOW_DEPTH = mmix_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned TERM_WIDTH   = mmix_pkg::TERM_WIDTH_DEF,
  localparam int unsigned IN_BITS  = 3 * TERM_WIDTH + 2 * mmix_pkg::PWM_W,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W    = 4 * mmix_pkg::PWM_W
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input items.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: roll_term, pitch_term, yaw_term, throttle_us, kill_us, zero pad
  input  wire logic [IN_W-1:0]               s_axis_tdata,
  // Result items.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: front_left_pwm, front_right_pwm, back_left_pwm, back_right_pwm
  output logic [OUT_W-1:0]                   m_axis_tdata,
  // tuser: motors_active
  output logic                               m_axis_tuser,
  // Configuration writes.
  input  wire logic                          cfg_we_i,
  input  wire logic [mmix_pkg::CADR_W-1:0]   cfg_addr_i,
  input  wire logic [mmix_pkg::PWM_W-1:0]    cfg_wdata_i
);

  localparam int unsigned PW   = mmix_pkg::PWM_W;
  localparam int unsigned WW   = mmix_pkg::WARM_W;
  localparam int unsigned TW   = TERM_WIDTH;
  localparam int unsigned OFS_THR  = 3 * TW;
  localparam int unsigned OFS_KILL = 3 * TW + PW;

  // Configuration registers.
  logic [PW-1:0] lift_min_q, lift_max_q, motor_min_q, motor_max_q;
  logic [PW-1:0] idle_pwm_q, kill_thr_q;
  logic [WW-1:0] warmup_items_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_min_q     <= mmix_pkg::LIFT_MIN_RST;
      lift_max_q     <= mmix_pkg::LIFT_MAX_RST;
      motor_min_q    <= mmix_pkg::MOTOR_MIN_RST;
      motor_max_q    <= mmix_pkg::MOTOR_MAX_RST;
      idle_pwm_q     <= mmix_pkg::IDLE_PWM_RST;
      kill_thr_q     <= mmix_pkg::KILL_THR_RST;
      warmup_items_q <= mmix_pkg::WARMUP_RST;
    end else if (cfg_we_i) begin
      unique case (mmix_pkg::cfg_idx_e'(cfg_addr_i))
        mmix_pkg::CFG_LIFT_MIN:  lift_min_q     <= cfg_wdata_i;
        mmix_pkg::CFG_LIFT_MAX:  lift_max_q     <= cfg_wdata_i;
        mmix_pkg::CFG_MOTOR_MIN: motor_min_q    <= cfg_wdata_i;
        mmix_pkg::CFG_MOTOR_MAX: motor_max_q    <= cfg_wdata_i;
        mmix_pkg::CFG_IDLE_PWM:  idle_pwm_q     <= cfg_wdata_i;
        mmix_pkg::CFG_KILL_THR:  kill_thr_q     <= cfg_wdata_i;
        mmix_pkg::CFG_WARMUP:    warmup_items_q <= cfg_wdata_i[WW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage advances when the one after it is free.
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_ready, s2_ready, s1_ready, accept;

  assign out_ready     = !out_v_q || m_axis_tready;
  assign s2_ready      = !s2_v_q || out_ready;
  assign s1_ready      = !s1_v_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign accept        = s_axis_tvalid && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_v_q  <= s_axis_tvalid;
      if (s2_ready)  s2_v_q  <= s1_v_q;
      if (out_ready) out_v_q <= s2_v_q;
    end
  end

  // Input stage: warm-up count and the idle decision for the item.
  logic [WW-1:0] warm_cnt_q, warm_cnt_d;
  logic [PW-1:0] in_thr, in_kill;
  logic [PW-1:0] s1_thr_q;
  logic          s1_idle_q;

  assign in_thr     = s_axis_tdata[OFS_THR +: PW];
  assign in_kill    = s_axis_tdata[OFS_KILL +: PW];
  assign warm_cnt_d = (warm_cnt_q < mmix_pkg::WARMUP_SAT) ? warm_cnt_q + WW'(1) : warm_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_cnt_q <= '0;
    end else if (accept) begin
      warm_cnt_q <= warm_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_thr_q  <= in_thr;
      s1_idle_q <= (in_kill > kill_thr_q) || (warm_cnt_d < warmup_items_q);
    end
  end

  // Term windows; their medians belong to the item held in the input stage.
  logic signed [TW:0] roll_x2, pitch_x2, yaw_x2;

  mmix_window #(.DEPTH(WINDOW_DEPTH), .WIDTH(TW)) u_roll_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (accept),
    .sample_i ($signed(s_axis_tdata[0 +: TW])),
    .med_x2_o (roll_x2)
  );

  mmix_window #(.DEPTH(WINDOW_DEPTH), .WIDTH(TW)) u_pitch_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (accept),
    .sample_i ($signed(s_axis_tdata[TW +: TW])),
    .med_x2_o (pitch_x2)
  );

  mmix_window #(.DEPTH(WINDOW_DEPTH), .WIDTH(TW)) u_yaw_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (accept),
    .sample_i ($signed(s_axis_tdata[2*TW +: TW])),
    .med_x2_o (yaw_x2)
  );

  // Median stage: medians and the clamped lift.
  logic signed [TW:0] roll_x2_q, pitch_x2_q, yaw_x2_q;
  logic [PW-1:0]      lift_d, lift_q;
  logic               s2_idle_q;

  always_comb begin
    priority if (s1_thr_q < lift_min_q) lift_d = lift_min_q;
    else if (s1_thr_q > lift_max_q)      lift_d = lift_max_q;
    else                                 lift_d = s1_thr_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      roll_x2_q  <= roll_x2;
      pitch_x2_q <= pitch_x2;
      yaw_x2_q   <= yaw_x2;
      lift_q     <= lift_d;
      s2_idle_q  <= s1_idle_q;
    end
  end

  // Mix stage into the output register.
  mmix_pkg::motor_lim_t motor_lim;
  logic [PW-1:0] fl, fr, bl, br;
  logic [PW-1:0] fl_q, fr_q, bl_q, br_q;
  logic          active_q;

  assign motor_lim.lo = motor_min_q;
  assign motor_lim.hi = motor_max_q;

  mmix_mixer #(.WIDTH(TW)) u_mixer (
    .roll_x2_i     (roll_x2_q),
    .pitch_x2_i    (pitch_x2_q),
    .yaw_x2_i      (yaw_x2_q),
    .lift_i        (lift_q),
    .lim_i         (motor_lim),
    .front_left_o  (fl),
    .front_right_o (fr),
    .back_left_o   (bl),
    .back_right_o  (br)
  );

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (s2_idle_q) begin
        fl_q <= idle_pwm_q;
        fr_q <= idle_pwm_q;
        bl_q <= idle_pwm_q;
        br_q <= idle_pwm_q;
      end else begin
        fl_q <= fl;
        fr_q <= fr;
        bl_q <= bl;
        br_q <= br;
      end
      active_q <= !s2_idle_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {br_q, bl_q, fr_q, fl_q};
  assign m_axis_tuser  = active_q;

  // An idle result carries one value on all four motors.
  a_idle_uniform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !active_q) |-> (fl_q == fr_q && fl_q == bl_q && fl_q == br_q))
    else $error("idle result with differing motor values");

  // The warm-up counter steps by one per accepted item until saturation.
  a_warm_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && warm_cnt_q != mmix_pkg::WARMUP_SAT) |=> (warm_cnt_q == $past(warm_cnt_q) + WW'(1)))
    else $error("warm-up counter did not advance");

  // Once saturated, the warm-up counter stays there.
  a_warm_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm_cnt_q == mmix_pkg::WARMUP_SAT) |=> (warm_cnt_q == mmix_pkg::WARMUP_SAT))
    else $error("warm-up counter left saturation");

  // Without an accepted item the counter holds.
  a_warm_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(warm_cnt_q))
    else $error("warm-up counter moved without an item");

endmodule : median_filtered_quad_motor_mixer_core

`default_nettype wire

FILE: rtl/core/mmix_window.sv
// Sliding window of one correction term with a parallel-rank median.
// Outputs the sum of the two middle ranks (median in half units).
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module mmix_window #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 12
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    shift_i,
  input  wire logic signed [WIDTH-1:0] sample_i,
  output logic signed [WIDTH:0]        med_x2_o
);

  localparam int unsigned RANK_W = $clog2(DEPTH);
  localparam logic [RANK_W-1:0] MID_LO = RANK_W'((DEPTH - 1) / 2);
  localparam logic [RANK_W-1:0] MID_HI = RANK_W'(DEPTH / 2);

  logic signed [WIDTH-1:0] win_q [DEPTH];
  logic [RANK_W-1:0]       rank   [DEPTH];
  logic signed [WIDTH-1:0] sel_lo;
  logic signed [WIDTH-1:0] sel_hi;

  // Shift line, newest sample at tap zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) win_q[i] <= '0;
    end else if (shift_i) begin
      win_q[0] <= sample_i;
      for (int i = 1; i < DEPTH; i++) win_q[i] <= win_q[i-1];
    end
  end

  // Rank of each tap: smaller entries, with ties broken by tap position,
  // so the ranks form a permutation of 0 .. DEPTH-1.
  always_comb begin
    logic [DEPTH-1:0] before_me;
    for (int i = 0; i < DEPTH; i++) begin
      for (int j = 0; j < DEPTH; j++) begin
        before_me[j] = (win_q[j] < win_q[i]) || ((j < i) && (win_q[j] == win_q[i]));
      end
      rank[i] = RANK_W'($countones(before_me));
    end
  end

  // Pick the two middle ranks; exactly one tap matches each.
  always_comb begin
    sel_lo = '0;
    sel_hi = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rank[i] == MID_LO) sel_lo = win_q[i];
      if (rank[i] == MID_HI) sel_hi = win_q[i];
    end
  end

  assign med_x2_o = (WIDTH+1)'(sel_lo) + (WIDTH+1)'(sel_hi);

endmodule : mmix_window

`default_nettype wire

FILE: rtl/core/mmix_mixer.sv
// Quad-X mixer: sums lift and medians in half units, halves toward zero
// and clamps each motor value. Uses mmix_pkg for widths and the limit struct.
`timescale 1ns / 1ps
`default_nettype none

module mmix_mixer #(
  parameter int unsigned WIDTH = 12
) (
  input  wire logic signed [WIDTH:0]         roll_x2_i,
  input  wire logic signed [WIDTH:0]         pitch_x2_i,
  input  wire logic signed [WIDTH:0]         yaw_x2_i,
  input  wire logic [mmix_pkg::PWM_W-1:0]    lift_i,
  input  wire mmix_pkg::motor_lim_t          lim_i,
  output logic [mmix_pkg::PWM_W-1:0]         front_left_o,
  output logic [mmix_pkg::PWM_W-1:0]         front_right_o,
  output logic [mmix_pkg::PWM_W-1:0]         back_left_o,
  output logic [mmix_pkg::PWM_W-1:0]         back_right_o
);

  localparam int unsigned PW = mmix_pkg::PWM_W;
  // Wide enough for twice the lift plus three medians in half units.
  localparam int unsigned SW = ((WIDTH + 1 > PW + 2) ? WIDTH + 1 : PW + 2) + 3;

  logic signed [SW-1:0] l2, r, p, y;
  logic signed [SW-1:0] lo, hi;

  assign l2 = $signed({{(SW-PW-1){1'b0}}, lift_i, 1'b0});
  assign r  = SW'(roll_x2_i);
  assign p  = SW'(pitch_x2_i);
  assign y  = SW'(yaw_x2_i);
  assign lo = $signed({{(SW-PW){1'b0}}, lim_i.lo});
  assign hi = $signed({{(SW-PW){1'b0}}, lim_i.hi});

  // Halve toward zero, then clamp; when limits cross, values below the lower limit take it and all others the upper.
  function automatic logic [PW-1:0] motor_val(input logic signed [SW-1:0] s,
                                              input logic signed [SW-1:0] lim_lo,
                                              input logic signed [SW-1:0] lim_hi);
    logic signed [SW-1:0] adj;
    logic signed [SW-1:0] v;
    adj = s + SW'({1'b0, s[SW-1]});
    v   = adj >>> 1;
    if (v < lim_lo)      motor_val = lim_lo[PW-1:0];
    else if (v > lim_hi) motor_val = lim_hi[PW-1:0];
    else                 motor_val = v[PW-1:0];
  endfunction

  assign front_left_o  = motor_val(l2 + r - p - y, lo, hi);
  assign front_right_o = motor_val(l2 - r - p + y, lo, hi);
  assign back_left_o   = motor_val(l2 + r + p + y, lo, hi);
  assign back_right_o  = motor_val(l2 - r + p - y, lo, hi);

endmodule : mmix_mixer

`default_nettype wire
